>>> sv/soft_timer_bank_assert.svh
// assertion macros used by the checker of the timer bank
`ifndef SOFT_TIMER_BANK_ASSERT_SVH
`define SOFT_TIMER_BANK_ASSERT_SVH

// checked only outside reset
`define STB_ASSERT_RUN(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define STB_ASSERT_ALL(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/stb_pkg.sv
`default_nettype none

package stb_pkg;

  localparam int NUM_CHANNELS_DEF = 8;
  localparam int MAX_RESULTS      = 8;
  localparam int RES_CNT_W        = 4;
  localparam int PERIOD_W         = 16;
  localparam int CHAN_W           = 3;
  localparam int KIND_W           = 3;

  // command codes as seen on in_kind
  typedef enum logic [KIND_W-1:0] {
    KIND_TICK   = 3'd0,
    KIND_ALLOC  = 3'd1,
    KIND_FREE   = 3'd2,
    KIND_START1 = 3'd3,
    KIND_STARTP = 3'd4,
    KIND_STOP   = 3'd5
  } kind_t;

  // classified operation carried through the queue
  typedef enum logic [2:0] {
    OP_TICK,
    OP_ALLOC,
    OP_FREE,
    OP_START,
    OP_STOP
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic                periodic;
    logic [CHAN_W-1:0]   channel;
    logic [PERIOD_W-1:0] period;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_FLUSH
  } back_state_t;

endpackage

`default_nettype wire

>>> sv/stb_front.sv
`default_nettype none

module stb_front #(
  parameter int NUM_CHANNELS = stb_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic                          start,
  input  wire logic [stb_pkg::KIND_W-1:0]    in_kind,
  input  wire logic [stb_pkg::CHAN_W-1:0]    in_channel,
  input  wire logic [stb_pkg::PERIOD_W-1:0]  in_period,
  input  wire stb_pkg::q_status_t            q_stat,
  output logic                               busy,
  output logic                               push,
  output stb_pkg::cmd_t                      cmd
);

  logic accept;
  logic in_range;
  logic keep;

  assign busy     = q_stat.full;
  assign accept   = start && !q_stat.full;
  assign in_range = (32'(in_channel) < NUM_CHANNELS);
  assign push     = accept && keep;

  // unused kinds and out of range channels are dropped here
  always_comb begin
    cmd.op       = stb_pkg::OP_TICK;
    cmd.periodic = 1'b0;
    cmd.channel  = in_channel;
    cmd.period   = in_period;
    keep         = 1'b0;
    case (stb_pkg::kind_t'(in_kind))
      stb_pkg::KIND_TICK: begin
        cmd.op = stb_pkg::OP_TICK;
        keep   = 1'b1;
      end
      stb_pkg::KIND_ALLOC: begin
        cmd.op = stb_pkg::OP_ALLOC;
        keep   = 1'b1;
      end
      stb_pkg::KIND_FREE: begin
        cmd.op = stb_pkg::OP_FREE;
        keep   = in_range;
      end
      stb_pkg::KIND_START1: begin
        cmd.op = stb_pkg::OP_START;
        keep   = in_range;
      end
      stb_pkg::KIND_STARTP: begin
        cmd.op       = stb_pkg::OP_START;
        cmd.periodic = 1'b1;
        keep         = in_range;
      end
      stb_pkg::KIND_STOP: begin
        cmd.op = stb_pkg::OP_STOP;
        keep   = in_range;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/stb_queue.sv
`default_nettype none

module stb_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire stb_pkg::cmd_t      push_cmd,
  input  wire logic               pop,
  output stb_pkg::cmd_t           head,
  output stb_pkg::q_status_t      q_stat
);

  stb_pkg::cmd_t mem_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

>>> sv/stb_back.sv
`default_nettype none

module stb_back #(
  parameter int NUM_CHANNELS = stb_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire stb_pkg::cmd_t                cmd,
  input  wire stb_pkg::q_status_t           q_stat,
  output logic                              pop,
  output logic                              out_strobe,
  output logic [stb_pkg::CHAN_W-1:0]        out_channel_out,
  output logic                              out_fired,
  output logic                              out_granted,
  output logic                              out_last
);

  localparam int IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SCAN_W = IDX_W + 1;
  localparam int CW     = stb_pkg::CHAN_W;
  localparam int PW     = stb_pkg::PERIOD_W;
  localparam int RW     = stb_pkg::RES_CNT_W;

  stb_pkg::back_state_t state_r, state_nxt;

  logic [NUM_CHANNELS-1:0] running_r, running_nxt;
  logic [NUM_CHANNELS-1:0] periodic_r, periodic_nxt;
  logic [NUM_CHANNELS-1:0] allocated_r, allocated_nxt;

  logic [SCAN_W-1:0] scan_r, scan_nxt;
  logic [IDX_W-1:0]  vis_idx_r, vis_idx_nxt;
  logic              hold_vld_r, hold_vld_nxt;
  logic [CW-1:0]     hold_ch_r, hold_ch_nxt;
  logic [RW-1:0]     cnt_r, cnt_nxt;

  logic          out_strobe_r, out_strobe_nxt;
  logic [CW-1:0] out_ch_r, out_ch_nxt;
  logic          out_fired_r, out_fired_nxt;
  logic          out_granted_r, out_granted_nxt;
  logic          out_last_r, out_last_nxt;

  // countdown and reload stores, one read and one write port each
  logic [PW-1:0]    rem_mem [NUM_CHANNELS];
  logic [PW-1:0]    rel_mem [NUM_CHANNELS];
  logic [PW-1:0]    rem_q, rel_q;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic             rem_we, rel_we;
  logic [PW-1:0]    rem_wd, rel_wd;

  logic [IDX_W+CW-1:0] cmd_ch_ext;
  logic [IDX_W-1:0]    cmd_idx;
  logic [IDX_W+CW-1:0] free_ext;
  logic [IDX_W+CW-1:0] vis_ext;
  logic [IDX_W-1:0]    scan_idx;
  logic                scan_done;
  logic                free_found;
  logic [IDX_W-1:0]    free_idx;

  assign cmd_ch_ext = {{IDX_W{1'b0}}, cmd.channel};
  assign cmd_idx    = cmd_ch_ext[IDX_W-1:0];
  assign free_ext   = {{CW{1'b0}}, free_idx};
  assign vis_ext    = {{CW{1'b0}}, vis_idx_r};
  assign scan_idx   = scan_r[IDX_W-1:0];
  assign scan_done  = (scan_r == SCAN_W'(NUM_CHANNELS));

  // lowest channel not allocated
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (!allocated_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      stb_pkg::BK_IDLE: begin
        if (!q_stat.empty && cmd.op == stb_pkg::OP_TICK) begin
          state_nxt = stb_pkg::BK_SCAN;
        end
      end
      stb_pkg::BK_SCAN: begin
        if (scan_done) begin
          state_nxt = stb_pkg::BK_FLUSH;
        end
      end
      stb_pkg::BK_FLUSH: begin
        state_nxt = stb_pkg::BK_IDLE;
      end
      default: begin
        state_nxt = stb_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    pop             = 1'b0;
    running_nxt     = running_r;
    periodic_nxt    = periodic_r;
    allocated_nxt   = allocated_r;
    scan_nxt        = scan_r;
    vis_idx_nxt     = vis_idx_r;
    hold_vld_nxt    = hold_vld_r;
    hold_ch_nxt     = hold_ch_r;
    cnt_nxt         = cnt_r;
    out_strobe_nxt  = 1'b0;
    out_ch_nxt      = '0;
    out_fired_nxt   = 1'b0;
    out_granted_nxt = 1'b0;
    out_last_nxt    = 1'b0;
    rd_addr         = '0;
    wr_addr         = cmd_idx;
    rem_we          = 1'b0;
    rel_we          = 1'b0;
    rem_wd          = cmd.period;
    rel_wd          = cmd.period;
    case (state_r)
      stb_pkg::BK_IDLE: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          case (cmd.op)
            stb_pkg::OP_TICK: begin
              scan_nxt     = SCAN_W'(1);
              vis_idx_nxt  = '0;
              rd_addr      = '0;
              cnt_nxt      = '0;
              hold_vld_nxt = 1'b0;
            end
            stb_pkg::OP_ALLOC: begin
              out_strobe_nxt = 1'b1;
              out_last_nxt   = 1'b1;
              if (free_found) begin
                allocated_nxt[free_idx] = 1'b1;
                running_nxt[free_idx]   = 1'b0;
                out_granted_nxt         = 1'b1;
                out_ch_nxt              = free_ext[CW-1:0];
              end
            end
            stb_pkg::OP_FREE: begin
              allocated_nxt[cmd_idx] = 1'b0;
            end
            stb_pkg::OP_START: begin
              rem_we                = 1'b1;
              rel_we                = 1'b1;
              running_nxt[cmd_idx]  = 1'b1;
              periodic_nxt[cmd_idx] = cmd.periodic;
            end
            stb_pkg::OP_STOP: begin
              running_nxt[cmd_idx] = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      stb_pkg::BK_SCAN: begin
        // read the next channel while this one is worked on
        if (!scan_done) begin
          rd_addr     = scan_idx;
          vis_idx_nxt = scan_idx;
          scan_nxt    = scan_r + SCAN_W'(1);
        end
        wr_addr = vis_idx_r;
        if (running_r[vis_idx_r]) begin
          if (rem_q != '0) begin
            rem_we = 1'b1;
            rem_wd = rem_q - PW'(1);
          end else begin
            // a fire is held back in the hold register so the final one can be marked
            if (cnt_r < RW'(stb_pkg::MAX_RESULTS)) begin
              cnt_nxt      = cnt_r + RW'(1);
              hold_vld_nxt = 1'b1;
              hold_ch_nxt  = vis_ext[CW-1:0];
              if (hold_vld_r) begin
                out_strobe_nxt = 1'b1;
                out_ch_nxt     = hold_ch_r;
                out_fired_nxt  = 1'b1;
              end
            end
            if (periodic_r[vis_idx_r]) begin
              rem_we = 1'b1;
              rem_wd = rel_q;
            end else begin
              running_nxt[vis_idx_r] = 1'b0;
            end
          end
        end
      end
      stb_pkg::BK_FLUSH: begin
        hold_vld_nxt = 1'b0;
        if (hold_vld_r) begin
          out_strobe_nxt = 1'b1;
          out_ch_nxt     = hold_ch_r;
          out_fired_nxt  = 1'b1;
          out_last_nxt   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= stb_pkg::BK_IDLE;
      running_r    <= '0;
      periodic_r   <= '0;
      allocated_r  <= '0;
      scan_r       <= '0;
      hold_vld_r   <= 1'b0;
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      running_r    <= running_nxt;
      periodic_r   <= periodic_nxt;
      allocated_r  <= allocated_nxt;
      scan_r       <= scan_nxt;
      hold_vld_r   <= hold_vld_nxt;
      cnt_r        <= cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vis_idx_r     <= vis_idx_nxt;
    hold_ch_r     <= hold_ch_nxt;
    out_ch_r      <= out_ch_nxt;
    out_fired_r   <= out_fired_nxt;
    out_granted_r <= out_granted_nxt;
    out_last_r    <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (rem_we) begin
      rem_mem[wr_addr] <= rem_wd;
    end
    if (rel_we) begin
      rel_mem[wr_addr] <= rel_wd;
    end
    rem_q <= rem_mem[rd_addr];
    rel_q <= rel_mem[rd_addr];
  end

  assign out_strobe      = out_strobe_r;
  assign out_channel_out = out_ch_r;
  assign out_fired       = out_fired_r;
  assign out_granted     = out_granted_r;
  assign out_last        = out_last_r;

endmodule

`default_nettype wire

>>> sv/soft_timer_bank.sv
// channel   ports                                        beat taken when
// command   start busy in_kind in_channel in_period      start && !busy at clk rise
// result    out_strobe out_channel_out out_fired         out_strobe high, one cycle
//           out_granted out_last
//
// a tick in the back end is issued, then sweeps one channel a cycle through
// the read port of the countdown store, then flushes the held fire
// allocate, free, start and stop are each handled in the back end's idle state
// results leave the back end through output registers, at most one a cycle
// busy rises only while the two-entry command queue is full
// reset is synchronous and clears all flags at once: no clearing pass
// the result side cannot stall: every strobed beat is taken
`default_nettype none

module soft_timer_bank #(
  parameter int NUM_CHANNELS = stb_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [stb_pkg::KIND_W-1:0]    in_kind,
  input  wire logic [stb_pkg::CHAN_W-1:0]    in_channel,
  input  wire logic [stb_pkg::PERIOD_W-1:0]  in_period,
  output logic                               out_strobe,
  output logic [stb_pkg::CHAN_W-1:0]         out_channel_out,
  output logic                               out_fired,
  output logic                               out_granted,
  output logic                               out_last
);

  // front to queue
  logic               push;
  stb_pkg::cmd_t      push_cmd;
  // queue to back
  logic               pop;
  stb_pkg::cmd_t      head;
  stb_pkg::q_status_t q_stat;

  // classifies each command beat and drops those that do nothing
  stb_front #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .start      (start),
    .in_kind    (in_kind),
    .in_channel (in_channel),
    .in_period  (in_period),
    .q_stat     (q_stat),
    .busy       (busy),
    .push       (push),
    .cmd        (push_cmd)
  );

  // short queue so the front can still take commands during a tick sweep until it fills
  stb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // channel state, countdown stores and the tick sweep
  stb_back #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (head),
    .q_stat          (q_stat),
    .pop             (pop),
    .out_strobe      (out_strobe),
    .out_channel_out (out_channel_out),
    .out_fired       (out_fired),
    .out_granted     (out_granted),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

>>> sv/stb_checker.sv
`default_nettype none
`include "soft_timer_bank_assert.svh"

module stb_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic [stb_pkg::KIND_W-1:0]    in_kind,
  input wire logic [stb_pkg::CHAN_W-1:0]    in_channel,
  input wire logic [stb_pkg::PERIOD_W-1:0]  in_period,
  input wire logic                          out_strobe,
  input wire logic [stb_pkg::CHAN_W-1:0]    out_channel_out,
  input wire logic                          out_fired,
  input wire logic                          out_granted,
  input wire logic                          out_last
);

  `STB_ASSERT_RUN(a_fire_not_grant, clk, rst_n, out_strobe |-> !(out_fired && out_granted), "fire beat also marked granted")
  `STB_ASSERT_RUN(a_alloc_is_last, clk, rst_n, (out_strobe && !out_fired) |-> out_last, "allocate beat not marked last")
  `STB_ASSERT_RUN(a_fail_chan_zero, clk, rst_n, (out_strobe && !out_fired && !out_granted) |-> (out_channel_out == '0), "failed allocate with non-zero channel")
  `STB_ASSERT_ALL(a_reset_quiet, clk, !rst_n |=> (!out_strobe && !busy), "result or busy straight after reset")

endmodule

bind soft_timer_bank stb_checker u_stb_checker (.*);

`default_nettype wire
